FILE: hw/rtl/brrb_pkg.sv
package brrb_pkg;

  localparam int MAX_LOG_DEF       = 10;
  localparam int ELEMENT_WIDTH_DEF = 32;

  localparam int SAMPLE_W = 32;
  localparam int POS_W    = 10;
  localparam int CFG_W    = 4;
  localparam int LOG_W    = 5;

  localparam logic [CFG_W-1:0] LOG_SIZE_RESET = 4'd10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_re;
    logic [SAMPLE_W-1:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out_re;
    logic [SAMPLE_W-1:0] out_im;
    logic [POS_W-1:0]    out_position;
    logic                out_last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_beat_t;

  // Map a written log_size onto the supported range: zero acts as one,
  // anything above the maximum acts as the maximum.
  function automatic logic [LOG_W-1:0] clamp_log(logic [CFG_W-1:0] v, int unsigned max_log);
    logic [LOG_W-1:0] l;
    l = LOG_W'(v);
    if (l == '0) begin
      l = LOG_W'(1);
    end else if (l > LOG_W'(max_log)) begin
      l = LOG_W'(max_log);
    end
    return l;
  endfunction

endpackage

FILE: hw/rtl/brrb_ram.sv
module brrb_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 2048,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/brrb_front.sv
module brrb_front
  import brrb_pkg::*;
#(
  parameter int MAX_LOG       = MAX_LOG_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic [QCNT_W-1:0] q_count,
  output result_beat_t      res
);

  localparam int ADDR_W = MAX_LOG + 1;
  localparam int SUM_W  = QCNT_W + 1;

  logic [MAX_LOG-1:0] wp_r, wp_nxt;
  logic               bank_r, bank_nxt;
  logic               ready_r, ready_nxt;
  logic [LOG_W-1:0]   shift_r, shift_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic [MAX_LOG-1:0] s1_pos_r;
  logic               s1_last_r;

  logic [MAX_LOG-1:0] mask;
  logic [MAX_LOG-1:0] pos;
  logic [MAX_LOG-1:0] rev_full;
  logic [MAX_LOG-1:0] rev;
  logic               is_last;
  logic               accept;

  logic [ADDR_W-1:0]          waddr;
  logic [ADDR_W-1:0]          raddr;
  logic [2*ELEMENT_WIDTH-1:0] wdata;
  logic [2*ELEMENT_WIDTH-1:0] rdata;

  always_comb begin
    mask    = {MAX_LOG{1'b1}} >> shift_r;
    pos     = wp_r & mask;
    is_last = (pos == mask);
    for (int i = 0; i < MAX_LOG; i++) begin
      rev_full[i] = pos[MAX_LOG-1-i];
    end
    // low bits of rev_full are zero below the frame size, so a right shift
    // leaves the reversal over the active width
    rev = rev_full >> shift_r;
  end

  // reserve a queue slot for the read still in flight
  assign in_full = (SUM_W'(q_count) + SUM_W'(s1_valid_r)) >= SUM_W'(QUEUE_DEPTH);
  assign accept  = in_push && !in_full;

  assign waddr = {bank_r, pos};
  assign raddr = {~bank_r, rev};
  assign wdata = {in_data.sample_im[ELEMENT_WIDTH-1:0], in_data.sample_re[ELEMENT_WIDTH-1:0]};

  brrb_ram #(
    .WIDTH (2 * ELEMENT_WIDTH),
    .DEPTH (2 ** ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    wp_nxt       = wp_r;
    bank_nxt     = bank_r;
    ready_nxt    = ready_r;
    shift_nxt    = shift_r;
    s1_valid_nxt = accept && ready_r;
    if (accept) begin
      if (is_last) begin
        wp_nxt    = '0;
        bank_nxt  = ~bank_r;
        ready_nxt = 1'b1;
      end else begin
        wp_nxt = pos + MAX_LOG'(1);
      end
    end
    // a new frame size restarts framing
    if (cfg_we) begin
      wp_nxt    = '0;
      ready_nxt = 1'b0;
      shift_nxt = LOG_W'(MAX_LOG) - clamp_log(cfg_wdata, MAX_LOG);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      bank_r     <= 1'b0;
      ready_r    <= 1'b0;
      shift_r    <= LOG_W'(MAX_LOG) - clamp_log(LOG_SIZE_RESET, MAX_LOG);
      s1_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      bank_r     <= bank_nxt;
      ready_r    <= ready_nxt;
      shift_r    <= shift_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r  <= pos;
      s1_last_r <= is_last;
    end
  end

  always_comb begin
    res.valid             = s1_valid_r;
    res.item.out_re       = SAMPLE_W'(rdata[ELEMENT_WIDTH-1:0]);
    res.item.out_im       = SAMPLE_W'(rdata[2*ELEMENT_WIDTH-1:ELEMENT_WIDTH]);
    res.item.out_position = POS_W'(s1_pos_r);
    res.item.out_last     = s1_last_r;
  end

endmodule

FILE: hw/rtl/brrb_queue.sv
module brrb_queue
  import brrb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  result_beat_t      res,
  input  logic              out_pop,
  output logic              out_empty,
  output out_item_t         out_data,
  output logic [QCNT_W-1:0] count
);

  out_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign out_empty = (count_r == '0);
  assign do_pop    = out_pop && !out_empty;
  assign out_data  = slot_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (res.valid) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    case ({res.valid, do_pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      slot_r[wr_ptr_r] <= res.item;
    end
  end

endmodule

FILE: hw/rtl/bit_reverse_reorder_buffer_top.sv
// Bit-reversal reorder buffer for FFT input frames.
// Input channel: in_data carries one complex sample (raw float bits) per beat,
// accepted on a rising edge with in_push high and in_full low. Samples of a
// frame arrive in natural order and go into one bank of a two-bank store.
// Output channel: while out_empty is low, out_data holds the oldest result;
// out_pop takes it. Each input beat after the first complete frame yields
// one result: the previous frame's sample at the bit-reversed position, with
// out_last set on the final position. The first frame yields nothing; feed
// the next frame to flush one out.
// Throughput is one beat per cycle while in_full is low: each beat does one store
// write and one reversed read on separate ports of the frame memory.
// A result passes the registered memory read and then the four-entry output
// queue before it can be popped.
// A stalled receiver fills the output queue; in_full rises so no result is
// dropped. cfg_we/cfg_wdata set log_size and restart framing; write it only
// while idle. Reset clears framing state and sets log_size to 10; the store
// itself is not cleared and needs no clearing pass.
module bit_reverse_reorder_buffer_top
  import brrb_pkg::*;
#(
  parameter int MAX_LOG       = MAX_LOG_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  in_item_t         in_data,
  input  logic             out_pop,
  output logic             out_empty,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  result_beat_t      res;
  logic [QCNT_W-1:0] q_count;

  brrb_front #(
    .MAX_LOG       (MAX_LOG),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_count   (q_count),
    .res       (res)
  );

  brrb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data),
    .count     (q_count)
  );

endmodule

FILE: dv/bit_reverse_reorder_buffer_top_test.sv
`timescale 1ns / 100ps

module bit_reverse_reorder_buffer_top_test;
  import brrb_pkg::*;

  class reorder_checker;
    logic [63:0]      frame_mem [0:2047];
    logic [9:0]       wr_pos;
    bit               bank;
    bit               frame_ready;
    logic [CFG_W-1:0] log_cfg;
    out_item_t        pending_outputs[$];
    int               errors;
    int               matched;

    function new();
      wr_pos      = '0;
      bank        = 1'b0;
      frame_ready = 1'b0;
      log_cfg     = LOG_SIZE_RESET;
      errors      = 0;
      matched     = 0;
    endfunction

    // Zero behaves as one, anything past the maximum as the maximum.
    function int frame_bits();
      int b;
      b = int'(log_cfg);
      if (b < 1) begin
        b = 1;
      end else if (b > MAX_LOG_DEF) begin
        b = MAX_LOG_DEF;
      end
      return b;
    endfunction

    function logic [9:0] reversed(logic [9:0] v, int bits);
      logic [9:0] r;
      r = '0;
      for (int k = 0; k < bits; k++) begin
        r = {r[8:0], v[k]};
      end
      return r;
    endfunction

    // A new size restarts framing; the bank toggle is kept.
    function void note_config(logic [CFG_W-1:0] v);
      log_cfg     = v;
      wr_pos      = '0;
      frame_ready = 1'b0;
    endfunction

    function void note_sample(in_item_t s);
      int         bits;
      logic [9:0] last_pos;
      logic [9:0] pos;
      logic [9:0] rd;
      logic [63:0] word;
      out_item_t  o;
      bits     = frame_bits();
      last_pos = 10'((1 << bits) - 1);
      pos      = wr_pos & last_pos;
      if (frame_ready) begin
        rd             = reversed(pos, bits);
        word           = frame_mem[{~bank, rd}];
        o.out_re       = word[31:0];
        o.out_im       = word[63:32];
        o.out_position = pos;
        o.out_last     = (pos == last_pos);
        pending_outputs.push_back(o);
      end
      frame_mem[{bank, pos}] = {s.sample_im, s.sample_re};
      if (pos == last_pos) begin
        wr_pos      = '0;
        bank        = ~bank;
        frame_ready = 1'b1;
      end else begin
        wr_pos = pos + 10'd1;
      end
    endfunction

    function void report_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (errors <= 30) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      if (pending_outputs.size() == 0) begin
        errors++;
        if (errors <= 30) begin
          $display("%0t: unexpected output beat, expected none, got re %h im %h pos %0d last %b",
                   $time, got.out_re, got.out_im, got.out_position, got.out_last);
        end
        return;
      end
      want = pending_outputs.pop_front();
      if (got !== want) begin
        errors++;
        if (got.out_re !== want.out_re) begin
          report_field("out_re", want.out_re, got.out_re);
        end
        if (got.out_im !== want.out_im) begin
          report_field("out_im", want.out_im, got.out_im);
        end
        if (got.out_position !== want.out_position) begin
          report_field("out_position", 32'(want.out_position), 32'(got.out_position));
        end
        if (got.out_last !== want.out_last) begin
          report_field("out_last", 32'(want.out_last), 32'(got.out_last));
        end
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  in_item_t         in_data = '0;
  logic             out_pop = 1'b0;
  logic             out_empty;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  reorder_checker sb;
  bit gaps_on = 1'b0;
  bit hold_now = 1'b0;
  int full_cycles = 0;
  int sent_total = 0;
  int size_writes = 0;

  bit_reverse_reorder_buffer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h7f80_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t random_sample();
    in_item_t s;
    s.sample_re = random_word();
    s.sample_im = random_word();
    return s;
  endfunction

  task automatic send_sample(input in_item_t s);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push = 1'b1;
    in_data = s;
    @(posedge clk);
    while (in_full) begin
      full_cycles++;
      @(posedge clk);
    end
    sb.note_sample(s);
    sent_total++;
  endtask

  // Hold input until every predicted output is out, then let the pipeline settle.
  task automatic wait_outputs_done();
    @(negedge clk);
    in_push = 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_log_size(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    sb.note_config(v);
    size_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_setting(input logic [CFG_W-1:0] v, input int count);
    write_log_size(v);
    repeat (count) send_sample(random_sample());
    wait_outputs_done();
  endtask

  // Output side: random pop gaps, plus one long hold on request.
  initial begin
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_now && hold_left == 0) begin
        hold_left = 60;
        hold_now  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop = 1'b0;
      end else begin
        if (idle_left == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
          idle_left = $urandom_range(1, 7);
        end
        if (idle_left > 0) begin
          idle_left--;
          out_pop = 1'b0;
        end else begin
          out_pop = 1'b1;
        end
      end
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        sb.check_output(out_data);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("bit_reverse_reorder_buffer_top test failed");
    $finish;
  end

  initial begin
    in_item_t s;
    int       log_v;
    int       eff;
    int       count;
    int       random_items;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset size, then the two-point frame through a zero write.
    send_sample(random_sample());
    send_sample(random_sample());
    wait_outputs_done();
    write_log_size(4'd0);
    s = '{sample_re: 32'h0000_0000, sample_im: 32'h0000_0000}; send_sample(s);
    s = '{sample_re: 32'hffff_ffff, sample_im: 32'hffff_ffff}; send_sample(s);
    s = '{sample_re: 32'h5555_5555, sample_im: 32'haaaa_aaaa}; send_sample(s);
    s = '{sample_re: 32'haaaa_aaaa, sample_im: 32'h5555_5555}; send_sample(s);
    s = '{sample_re: 32'h7f80_0000, sample_im: 32'hff80_0000}; send_sample(s);
    s = '{sample_re: 32'h7fc0_0000, sample_im: 32'h8000_0000}; send_sample(s);
    wait_outputs_done();
    // Eight-point frames with position-coded samples.
    write_log_size(4'd3);
    for (int i = 0; i < 16; i++) begin
      s.sample_re = 32'h3f80_0000 | 32'(i);
      s.sample_im = 32'hc000_0000 | 32'(i << 4);
      send_sample(s);
    end
    wait_outputs_done();

    // Random small sizes, ending some settings on a partial frame.
    random_items = 0;
    while (random_items < 850) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: log_v = 0;
        1: log_v = 7;
        default: log_v = $urandom_range(1, 6);
      endcase
      eff   = (log_v == 0) ? 1 : log_v;
      count = $urandom_range(2, 3) * (1 << eff) + $urandom_range(0, (1 << eff) - 1);
      run_setting(4'(log_v), count);
      random_items += count;
    end

    // 32-point frames: long output hold to back up the input, then a drain pause.
    gaps_on = 1'b1;
    write_log_size(4'd5);
    for (int i = 0; i < 2 * 32 + 40; i++) begin
      if (i == 50) begin
        hold_now = 1'b1;
      end
      if (i == 80) begin
        wait_outputs_done();
      end
      send_sample(random_sample());
    end
    wait_outputs_done();

    // Closing stretch with no gaps on either side.
    gaps_on = 1'b0;
    run_setting(4'd2, 3 * 4 + 1);
    run_setting(4'd5, 3 * 32 + 7);
    repeat (6) @(posedge clk);

    $display("Sent %0d samples over %0d frame-size writes; %0d reordered beats matched.",
             sent_total, size_writes, sb.matched);
    $display("Input held off by full for %0d cycles.", full_cycles);
    if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
      $display("bit_reverse_reorder_buffer_top test passed");
    end else begin
      $display("bit_reverse_reorder_buffer_top test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/brrb_pkg.sv
hw/rtl/brrb_ram.sv
hw/rtl/brrb_front.sv
hw/rtl/brrb_queue.sv
hw/rtl/bit_reverse_reorder_buffer_top.sv
dv/bit_reverse_reorder_buffer_top_test.sv
